>>> hdl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
`default_nettype none
package iee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SYMBOL    = 2'd1,
        ERR_DIVZERO   = 2'd2,
        ERR_MALFORMED = 2'd3
    } err_t;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // Commands from controller to datapath.
    typedef struct packed {
        logic        clear;       // reset counts for next expression
        logic        push_digit;  // push digit value
        logic [31:0] digit;
        logic        push_op;
        op_t         op;
        logic        pop_op;      // drop top operator (matching paren)
        logic        reduce;      // start one reduction
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic             busy;
        logic             done;     // reduction finished this cycle
        err_t             red_err;  // error of finished reduction
        logic [CNT_W-1:0] vcnt;
        logic [CNT_W-1:0] ocnt;
        op_t              top_op;
        logic [31:0]      bottom;   // value_stack[0]
    } dp_stat_t;

    function automatic logic [1:0] prec_of(input op_t op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_MUL || op == OP_DIV)
            p = 2'd2;
        else if (op == OP_ADD || op == OP_SUB)
            p = 2'd1;
        return p;
    endfunction

endpackage
`default_nettype wire

>>> hdl/infix_expression_evaluator.sv
// Top level: infix expression evaluator with stream ports.
// Sequencing: a digit or '(' is pushed as it is taken; an operator or ')' passes through its
//   own state, then each reduction runs read and writeback for + or -, read, multiply and
//   writeback for *, read, divider (one quotient bit a cycle) and writeback for /, read only
//   on divide by zero. One symbol at a time; the last then passes the final and emit states.
// The result sits in an output register; the next symbol is taken while it waits.
// Reset (rst_n low, asynchronous) empties both stacks and clears the error.
`default_nettype none
module infix_expression_evaluator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,   // last symbol of the expression
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);
    import iee_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] value;
    logic [1:0]  status;

    // Controller walks each symbol through its reductions.
    iee_control u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_symbol  (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (value),
        .out_status (status),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Datapath holds the stacks and the arithmetic.
    iee_datapath u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign m_tdata = {6'd0, status, value};

endmodule
`default_nettype wire

>>> hdl/iee_datapath.sv
// Stacks, arithmetic unit and serial divider of the evaluator.
`default_nettype none
module iee_datapath
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iee_pkg::dp_cmd_t  cmd,
    output iee_pkg::dp_stat_t      stat
);
    import iee_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } dst_t;

    logic [31:0] vstk [STACK_DEPTH];
    op_t         ostk [STACK_DEPTH];
    logic [CNT_W-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    dst_t        st_reg, st_next;
    logic [31:0] lhs_reg, rhs_reg, res_reg, res_next;
    op_t         rop_reg;
    logic [31:0] quo_reg, quo_next, rem_reg, rem_next, div_reg;
    logic        neg_reg;
    logic [5:0]  bit_reg, bit_next;
    logic        done_reg, done_next;
    err_t        rerr_reg, rerr_next;
    logic [32:0] trial;
    logic [31:0] ma, mb;

    assign ma = lhs_reg[31] ? (32'd0 - lhs_reg) : lhs_reg;
    assign mb = rhs_reg[31] ? (32'd0 - rhs_reg) : rhs_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, div_reg};

    always_comb
    begin
        st_next   = st_reg;
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        res_next  = res_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        rerr_next = rerr_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd.clear)
                begin
                    vcnt_next = '0;
                    ocnt_next = '0;
                end
                if (cmd.push_digit)
                    vcnt_next = vcnt_reg + 1'b1;
                if (cmd.push_op)
                    ocnt_next = ocnt_reg + 1'b1;
                if (cmd.pop_op)
                    ocnt_next = ocnt_reg - 1'b1;
                if (cmd.reduce)
                begin
                    ocnt_next = ocnt_reg - 1'b1;
                    vcnt_next = vcnt_reg - 2'd2;
                    st_next   = S_READ;
                end
            end
            S_READ:
            begin
                rerr_next = ERR_NONE;
                case (rop_reg)
                    OP_ADD: begin res_next = lhs_reg + rhs_reg; st_next = S_WB; end
                    OP_SUB: begin res_next = lhs_reg - rhs_reg; st_next = S_WB; end
                    OP_MUL: st_next = S_MUL;
                    OP_DIV:
                    begin
                        if (rhs_reg == 32'd0)
                        begin
                            rerr_next = ERR_DIVZERO;
                            done_next = 1'b1;
                            st_next   = S_IDLE;
                        end
                        else
                        begin
                            quo_next = ma;
                            rem_next = '0;
                            bit_next = 6'd32;
                            st_next  = S_DIV;
                        end
                    end
                    default:
                    begin
                        rerr_next = ERR_MALFORMED;
                        done_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                res_next = lhs_reg * rhs_reg;
                st_next  = S_WB;
            end
            S_DIV:
            begin
                // one restoring quotient bit per cycle
                if (trial[32])
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 6'd1)
                begin
                    res_next = neg_reg ? (32'd0 - quo_next) : quo_next;
                    st_next  = S_WB;
                end
            end
            S_WB:
            begin
                // stack had two free slots after the pops, so no overflow
                vcnt_next = vcnt_reg + 1'b1;
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            vcnt_reg <= '0;
            ocnt_reg <= '0;
            done_reg <= 1'b0;
            rerr_reg <= ERR_NONE;
        end
        else
        begin
            st_reg   <= st_next;
            vcnt_reg <= vcnt_next;
            ocnt_reg <= ocnt_next;
            done_reg <= done_next;
            rerr_reg <= rerr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        if (st_reg == S_IDLE && cmd.reduce)
        begin
            lhs_reg <= vstk[SP_W'(vcnt_reg - 2'd2)];
            rhs_reg <= vstk[SP_W'(vcnt_reg - 1'b1)];
            rop_reg <= ostk[SP_W'(ocnt_reg - 1'b1)];
        end
        if (st_reg == S_READ)
        begin
            div_reg <= mb;
            neg_reg <= lhs_reg[31] ^ rhs_reg[31];
        end
        if (st_reg == S_IDLE && cmd.push_digit)
            vstk[SP_W'(vcnt_reg)] <= cmd.digit;
        if (st_reg == S_WB)
            vstk[SP_W'(vcnt_reg)] <= res_reg;
        if (st_reg == S_IDLE && cmd.push_op)
            ostk[SP_W'(ocnt_reg)] <= cmd.op;
    end

    always_comb
    begin
        stat.busy    = (st_reg != S_IDLE);
        stat.done    = done_reg;
        stat.red_err = rerr_reg;
        stat.vcnt    = vcnt_reg;
        stat.ocnt    = ocnt_reg;
        stat.top_op  = ostk[SP_W'(ocnt_reg - 1'b1)];
        stat.bottom  = vstk[0];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= CNT_W'(STACK_DEPTH) && ocnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_DIV |-> bit_reg != 6'd0)
        else $error("divider ran past last bit");
    a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_WB |=> done_reg)
        else $error("writeback without done");

endmodule
`default_nettype wire

>>> hdl/iee_control.sv
// Controller that sequences symbols into stack commands.
`default_nettype none
module iee_control
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_symbol,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            out_value,
    output logic [1:0]             out_status,
    output iee_pkg::dp_cmd_t       cmd,
    input  wire iee_pkg::dp_stat_t stat
);
    import iee_pkg::*;

    typedef enum logic [5:0] {
        C_IDLE  = 6'b000001,
        C_RPAR  = 6'b000010,
        C_OPER  = 6'b000100,
        C_FINAL = 6'b001000,
        C_WAIT  = 6'b010000,
        C_EMIT  = 6'b100000
    } cst_t;

    cst_t        st_reg, st_next, ret_reg, ret_next;
    err_t        err_reg, err_next;
    op_t         op_reg, op_next;
    logic        last_reg, last_next;
    logic        ov_reg, ov_next;
    logic [31:0] val_reg, val_next;
    logic [1:0]  sts_reg, sts_next;
    logic        full_v, full_o, can_red, is_digit;

    assign full_v   = stat.vcnt == CNT_W'(STACK_DEPTH);
    assign full_o   = stat.ocnt == CNT_W'(STACK_DEPTH);
    assign can_red  = stat.vcnt >= CNT_W'(2);
    assign is_digit = in_symbol >= CH_0 && in_symbol <= CH_9;
    assign in_ready = (st_reg == C_IDLE);
    assign out_valid  = ov_reg;
    assign out_value  = val_reg;
    assign out_status = sts_reg;

    always_comb
    begin
        st_next   = st_reg;
        ret_next  = ret_reg;
        err_next  = err_reg;
        op_next   = op_reg;
        last_next = last_reg;
        ov_next   = ov_reg && !out_ready;
        val_next  = val_reg;
        sts_next  = sts_reg;
        cmd       = '0;
        cmd.digit = {24'd0, in_symbol - CH_0};
        unique case (st_reg)
            C_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    last_next = in_last;
                    st_next   = in_last ? C_FINAL : C_IDLE;
                    if (err_reg == ERR_NONE)
                    begin
                        if (is_digit)
                        begin
                            if (full_v) err_next = ERR_MALFORMED;
                            else cmd.push_digit = 1'b1;
                        end
                        else if (in_symbol == CH_LPAREN)
                        begin
                            if (full_o) err_next = ERR_MALFORMED;
                            else
                            begin
                                cmd.push_op = 1'b1;
                                cmd.op      = OP_LPAREN;
                            end
                        end
                        else if (in_symbol == CH_RPAREN)
                            st_next = C_RPAR;
                        else if (in_symbol == CH_PLUS || in_symbol == CH_MINUS
                                 || in_symbol == CH_STAR || in_symbol == CH_SLASH)
                        begin
                            op_next = (in_symbol == CH_PLUS)  ? OP_ADD :
                                      (in_symbol == CH_MINUS) ? OP_SUB :
                                      (in_symbol == CH_STAR)  ? OP_MUL : OP_DIV;
                            st_next = C_OPER;
                        end
                        else
                            err_next = ERR_SYMBOL;
                    end
                end
            end
            C_RPAR:
            begin
                if (err_reg != ERR_NONE)
                    st_next = last_reg ? C_FINAL : C_IDLE;
                else if (stat.ocnt == '0)
                    err_next = ERR_MALFORMED;
                else if (stat.top_op == OP_LPAREN)
                begin
                    cmd.pop_op = 1'b1;
                    st_next    = last_reg ? C_FINAL : C_IDLE;
                end
                else if (!can_red)
                    err_next = ERR_MALFORMED;
                else
                begin
                    cmd.reduce = 1'b1;
                    ret_next   = C_RPAR;
                    st_next    = C_WAIT;
                end
            end
            C_OPER:
            begin
                if (err_reg != ERR_NONE)
                    st_next = last_reg ? C_FINAL : C_IDLE;
                else if (stat.ocnt != '0 && stat.top_op != OP_LPAREN
                         && prec_of(stat.top_op) >= prec_of(op_reg))
                begin
                    if (!can_red) err_next = ERR_MALFORMED;
                    else
                    begin
                        cmd.reduce = 1'b1;
                        ret_next   = C_OPER;
                        st_next    = C_WAIT;
                    end
                end
                else
                begin
                    if (full_o) err_next = ERR_MALFORMED;
                    else
                    begin
                        cmd.push_op = 1'b1;
                        cmd.op      = op_reg;
                    end
                    st_next = last_reg ? C_FINAL : C_IDLE;
                end
            end
            C_FINAL:
            begin
                if (err_reg == ERR_NONE && stat.ocnt != '0)
                begin
                    if (stat.top_op == OP_LPAREN || !can_red)
                        err_next = ERR_MALFORMED;
                    else
                    begin
                        cmd.reduce = 1'b1;
                        ret_next   = C_FINAL;
                        st_next    = C_WAIT;
                    end
                end
                else
                begin
                    if (err_reg == ERR_NONE && stat.vcnt != CNT_W'(1))
                        err_next = ERR_MALFORMED;
                    st_next = C_EMIT;
                end
            end
            C_WAIT:
            begin
                if (stat.done)
                begin
                    if (err_reg == ERR_NONE)
                        err_next = stat.red_err;
                    st_next = ret_reg;
                end
            end
            C_EMIT:
            begin
                // hold until output register frees
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    sts_next  = err_reg;
                    val_next  = (err_reg == ERR_NONE) ? stat.bottom : 32'd0;
                    err_next  = ERR_NONE;
                    cmd.clear = 1'b1;
                    st_next   = C_IDLE;
                end
            end
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_IDLE;
            ret_reg  <= C_IDLE;
            err_reg  <= ERR_NONE;
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ret_reg  <= ret_next;
            err_reg  <= err_next;
            ov_reg   <= ov_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        sts_reg <= sts_next;
    end

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ERR_NONE |-> out_value == 32'd0)
        else $error("error result carries a value");
    a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == C_WAIT && !stat.done |-> stat.busy)
        else $error("waiting on idle datapath");
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(err_reg) != ERR_NONE && $past(st_reg) != C_EMIT |-> err_reg == $past(err_reg))
        else $error("error code changed before end of expression");

endmodule
`default_nettype wire

>>> verif/infix_expression_evaluator_tb.sv
// Self-checking testbench for the infix expression evaluator stream block.
`default_nettype none
module infix_expression_evaluator_tb;
    import iee_pkg::*;

    typedef struct {
        logic [7:0] sym;
        logic       last;
        logic       known;   // expected result typed in below
        logic [31:0] val;
        err_t       st;
    } row_t;

    typedef struct {
        logic [31:0] val;
        err_t        st;
    } eval_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    infix_expression_evaluator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 clk = ~clk;

    // Predictor state: its own copy of the two stacks.
    logic [31:0] vals [STACK_DEPTH];
    op_t         ops  [STACK_DEPTH];
    int          nvals, nops;
    err_t        perr;

    eval_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;

    function automatic int rank(op_t o);
        if (o == OP_MUL || o == OP_DIV) return 2;
        if (o == OP_ADD || o == OP_SUB) return 1;
        return 0;
    endfunction

    function automatic void flag(err_t e);
        if (perr == ERR_NONE) perr = e;
    endfunction

    function automatic void push_val(logic [31:0] v);
        if (nvals >= STACK_DEPTH) flag(ERR_MALFORMED);
        else begin vals[nvals] = v; nvals++; end
    endfunction

    function automatic void push_opr(op_t o);
        if (nops >= STACK_DEPTH) flag(ERR_MALFORMED);
        else begin ops[nops] = o; nops++; end
    endfunction

    function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Pop one operator and two values, push lhs op rhs.
    function automatic void fold_top();
        op_t o;
        logic [31:0] l, r, res;
        if (nops == 0 || nvals < 2) begin flag(ERR_MALFORMED); return; end
        nops--; o = ops[nops];
        nvals--; r = vals[nvals];
        nvals--; l = vals[nvals];
        case (o)
            OP_ADD: res = l + r;
            OP_SUB: res = l - r;
            OP_MUL: res = l * r;
            OP_DIV: begin
                if (r == 0) begin flag(ERR_DIVZERO); return; end
                res = quot_trunc(l, r);
            end
            default: begin flag(ERR_MALFORMED); return; end
        endcase
        push_val(res);
    endfunction

    function automatic void absorb(logic [7:0] s);
        op_t o;
        if (s >= CH_0 && s <= CH_9) begin push_val(32'(s - CH_0)); return; end
        if (s == CH_LPAREN) begin push_opr(OP_LPAREN); return; end
        if (s == CH_RPAREN) begin
            while (perr == ERR_NONE) begin
                if (nops == 0) begin flag(ERR_MALFORMED); return; end
                if (ops[nops-1] == OP_LPAREN) begin nops--; return; end
                fold_top();
            end
            return;
        end
        case (s)
            CH_PLUS:  o = OP_ADD;
            CH_MINUS: o = OP_SUB;
            CH_STAR:  o = OP_MUL;
            CH_SLASH: o = OP_DIV;
            default: begin flag(ERR_SYMBOL); return; end
        endcase
        while (perr == ERR_NONE && nops > 0 && ops[nops-1] != OP_LPAREN
               && rank(ops[nops-1]) >= rank(o))
            fold_top();
        if (perr == ERR_NONE) push_opr(o);
    endfunction

    // Advance the predictor by one symbol; return 1 when a result is due.
    function automatic bit evaluate_symbol(logic [7:0] s, logic lst,
                                           output eval_result_t r);
        r.val = '0;
        r.st  = ERR_NONE;
        if (perr == ERR_NONE) absorb(s);
        if (!lst) return 1'b0;
        while (perr == ERR_NONE && nops > 0) begin
            if (ops[nops-1] == OP_LPAREN) flag(ERR_MALFORMED);
            else fold_top();
        end
        if (perr == ERR_NONE && nvals != 1) flag(ERR_MALFORMED);
        if (perr == ERR_NONE) r.val = vals[0];
        r.st = perr;
        nvals = 0; nops = 0; perr = ERR_NONE;
        return 1'b1;
    endfunction

    // Hand one symbol over on the slave side; waits for the handshake.
    task automatic send_symbol(logic [7:0] s, logic lst);
        eval_result_t r;
        int gap;
        gap = 0;
        if ($urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (evaluate_symbol(s, lst, r)) pending_results.push_back(r);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Well-formed random expression with random nesting, built as a queue of symbols.
    function automatic void build_expr(ref logic [7:0] q[$], input int lvl);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) q.push_back(pick_op());
            if (lvl < 3 && $urandom_range(0, 4) == 0) begin
                q.push_back(CH_LPAREN);
                build_expr(q, lvl + 1);
                q.push_back(CH_RPAREN);
            end else
                q.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end
    endfunction

    // Directed table: edge cases, result typed in where it is obvious.
    row_t rows[] = '{
        '{8'h30, 1, 1, 32'd0, ERR_NONE},          // "0"
        '{8'h39, 1, 1, 32'd9, ERR_NONE},          // "9"
        '{8'h37, 0, 0, 0, ERR_NONE},              // "7-2-1" left assoc
        '{CH_MINUS, 0, 0, 0, ERR_NONE},
        '{8'h32, 0, 0, 0, ERR_NONE},
        '{CH_MINUS, 0, 0, 0, ERR_NONE},
        '{8'h31, 1, 0, 0, ERR_NONE},
        '{8'h32, 0, 0, 0, ERR_NONE},              // "2+3*(4/1)"
        '{CH_PLUS, 0, 0, 0, ERR_NONE},
        '{8'h33, 0, 0, 0, ERR_NONE},
        '{CH_STAR, 0, 0, 0, ERR_NONE},
        '{CH_LPAREN, 0, 0, 0, ERR_NONE},
        '{8'h34, 0, 0, 0, ERR_NONE},
        '{CH_SLASH, 0, 0, 0, ERR_NONE},
        '{8'h31, 0, 0, 0, ERR_NONE},
        '{CH_RPAREN, 1, 0, 0, ERR_NONE},
        '{8'h35, 0, 1, 0, ERR_NONE},              // "5/0"
        '{CH_SLASH, 0, 1, 0, ERR_NONE},
        '{8'h30, 1, 1, 32'd0, ERR_DIVZERO},
        '{8'hFF, 1, 1, 32'd0, ERR_SYMBOL},        // unknown symbol
        '{CH_RPAREN, 1, 1, 32'd0, ERR_MALFORMED}, // unmatched close
        '{CH_LPAREN, 1, 1, 32'd0, ERR_MALFORMED}, // unmatched open
        '{CH_PLUS, 1, 1, 32'd0, ERR_MALFORMED},   // missing operand
        '{8'h31, 0, 1, 0, ERR_NONE},              // adjacent digits
        '{8'h32, 1, 1, 32'd0, ERR_MALFORMED}
    };

    // Long receiver hold-off while the sender keeps offering.
    task automatic stall_receiver();
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    endtask

    // Receiver: always ready in one window of each period, random backpressure otherwise, not ready during hold-off.
    always @(negedge clk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (cycles % 2000 < 500)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
    end

    // Check each result transaction against the oldest expectation.
    always @(posedge clk) begin
        eval_result_t e;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.val || m_tdata[33:32] !== e.st
                    || m_tdata[39:34] !== 6'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected value %h status %0d, got %h",
                                 e.val, e.st, m_tdata);
                end
            end
        end
    end

    // Directed rows with typed-in answers are also checked at the source.
    initial begin
        logic [7:0] expr[$];
        eval_result_t r;
        int sent;
        nvals = 0; nops = 0; perr = ERR_NONE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i]) begin
            send_symbol(rows[i].sym, rows[i].last);
            if (rows[i].known && rows[i].last) begin
                r = pending_results[$];
                if (r.val !== rows[i].val || r.st !== rows[i].st) begin
                    errors++;
                    if (errors <= 10)
                        $display("table row %0d: expected %h/%0d, predicted %h/%0d",
                                 i, rows[i].val, rows[i].st, r.val, r.st);
                end
            end
        end
        // Deep nesting: overflow of the operator stack.
        for (int i = 0; i < STACK_DEPTH + 1; i++) send_symbol(CH_LPAREN, 1'b0);
        send_symbol(8'h31, 1'b1);
        // Long sum: 9+9+... folds at each operator, so the value stack stays shallow.
        for (int i = 0; i < STACK_DEPTH + 1; i++) begin
            send_symbol(8'h39, 1'b0);
            send_symbol(CH_PLUS, 1'b0);
        end
        send_symbol(8'h39, 1'b1);
        sent = 0;
        fork
            stall_receiver();
        join_none
        while (sent < 1600) begin
            expr.delete();
            case ($urandom_range(0, 9))
                0: begin   // noise: random bytes
                    repeat ($urandom_range(1, 6)) expr.push_back(8'($urandom));
                end
                1: begin   // broken: drop a symbol
                    build_expr(expr, 0);
                    expr.delete($urandom_range(0, expr.size() - 1));
                    if (expr.size() == 0) expr.push_back(CH_RPAREN);
                end
                2: begin   // big products to force wrap and large division
                    build_expr(expr, 0);
                    repeat (8) begin
                        expr.push_back(CH_STAR);
                        expr.push_back(8'h39);
                    end
                    expr.push_back(pick_op());
                    expr.push_back(8'(CH_0 + $urandom_range(0, 9)));
                end
                default: build_expr(expr, 0);
            endcase
            foreach (expr[k]) begin
                send_symbol(expr[k], k == expr.size() - 1);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // End of run and watchdog.
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0 && cycles < 2000000) @(posedge clk);
        repeat (200) @(posedge clk);
        if (cycles >= 2000000) begin
            $display("DONE: errors detected");
        end else if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 2500000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

>>> infix_expression_evaluator.f
hdl/iee_pkg.sv
hdl/iee_datapath.sv
hdl/iee_control.sv
hdl/infix_expression_evaluator.sv
verif/infix_expression_evaluator_tb.sv
